@@ rtl/core/window_parity_operator_macros.svh @@
`ifndef WINDOW_PARITY_OPERATOR_MACROS_SVH
`define WINDOW_PARITY_OPERATOR_MACROS_SVH

// Property that must hold at every clock edge outside of reset.
`define WPO_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property whose consequent must hold in the cycle after the antecedent.
`define WPO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/wpo_pkg.sv @@
`timescale 1ns / 1ps
package wpo_pkg;

  localparam int unsigned PIX_W         = 16;
  localparam int unsigned ENTRY_W       = PIX_W + 1;
  localparam int unsigned SHAPE_W       = 25;
  localparam int unsigned WIDTH_FIELD_W = 11;
  localparam int unsigned ROW_W         = 16;
  localparam int unsigned LABEL_W       = 8;
  localparam int unsigned WIN_SIDE_MAX  = 7;

  localparam int unsigned DEF_MAX_WIDTH   = 1024;
  localparam int unsigned DEF_WINDOW_SIDE = 5;

  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [ROW_W-1:0]         ROW_MAX     = '1;
  localparam logic [LABEL_W-1:0]       LABEL_ODD   = 8'd255;
  localparam logic [LABEL_W-1:0]       LABEL_EVEN  = 8'd0;
  localparam logic [SHAPE_W-1:0]       SHAPE_RESET = 25'd473536;
  localparam logic                     MODE_RESET  = 1'b0;
  localparam logic [WIDTH_FIELD_W-1:0] WIDTH_RESET = 11'd1024;

  typedef enum logic [1:0] {
    REG_SHAPE = 2'd0,
    REG_MODE  = 2'd1,
    REG_WIDTH = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [SHAPE_W-1:0]       shape;
    logic                     same_label;
    logic [WIDTH_FIELD_W-1:0] width;
  } cfg_t;

  // Per-item window validity: which window rows and columns lie inside the image.
  typedef struct packed {
    logic                    centre_ok;
    logic [WIN_SIDE_MAX-1:0] row_ok;
    logic [WIN_SIDE_MAX-1:0] col_ok;
  } win_ctrl_t;

endpackage

@@ rtl/core/wpo_cfg_regs.sv @@
`timescale 1ns / 1ps
module wpo_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [wpo_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [wpo_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [wpo_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready,
  output wpo_pkg::cfg_t                    cfg
);
  import wpo_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  cfg_reg_t sel;
  logic     wr_en;

  assign sel    = cfg_reg_t'(paddr[CFG_ADDR_W-1:2]);
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    prdata  = '0;
    case (sel)
      REG_SHAPE: begin
        prdata = CFG_DATA_W'(cfg_r.shape);
        if (wr_en) cfg_nxt.shape = pwdata[SHAPE_W-1:0];
      end
      REG_MODE: begin
        prdata = CFG_DATA_W'(cfg_r.same_label);
        if (wr_en) cfg_nxt.same_label = pwdata[0];
      end
      REG_WIDTH: begin
        prdata = CFG_DATA_W'(cfg_r.width);
        if (wr_en) cfg_nxt.width = pwdata[WIDTH_FIELD_W-1:0];
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.shape      <= SHAPE_RESET;
      cfg_r.same_label <= MODE_RESET;
      cfg_r.width      <= WIDTH_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ rtl/core/wpo_hist_mem.sv @@
`timescale 1ns / 1ps
module wpo_hist_mem #(
  parameter  int unsigned DEPTH  = 2,
  parameter  int unsigned DATA_W = 1,
  localparam int unsigned AW     = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr_a,
  input  logic [AW-1:0]     rd_addr_b,
  output logic [DATA_W-1:0] rd_data_a,
  output logic [DATA_W-1:0] rd_data_b
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_a_r;
  logic [DATA_W-1:0] rd_data_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  // Read data only moves when a new item enters, so it holds through a stall.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a_r <= mem[rd_addr_a];
      rd_data_b_r <= mem[rd_addr_b];
    end
  end

  assign rd_data_a = rd_data_a_r;
  assign rd_data_b = rd_data_b_r;

endmodule

@@ rtl/core/wpo_raster_ctrl.sv @@
`timescale 1ns / 1ps
`include "window_parity_operator_macros.svh"
module wpo_raster_ctrl #(
  parameter  int unsigned MAX_WIDTH   = wpo_pkg::DEF_MAX_WIDTH,
  parameter  int unsigned WINDOW_SIDE = wpo_pkg::DEF_WINDOW_SIDE,
  localparam int unsigned HIST_DEPTH  = (WINDOW_SIDE - 1) * MAX_WIDTH + 1,
  localparam int unsigned AW          = $clog2(HIST_DEPTH),
  localparam int unsigned WORD_W      = WINDOW_SIDE * wpo_pkg::ENTRY_W
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic [wpo_pkg::PIX_W-1:0]     pix,
  input  logic                          mask,
  input  logic                          frame_start,
  input  wpo_pkg::cfg_t                 cfg,
  output logic [AW-1:0]                 wr_addr,
  output logic [WORD_W-1:0]             wr_word,
  output logic [WINDOW_SIDE-2:0][AW-1:0] rd_addr,
  output logic [WORD_W-1:0]             row_new,
  output wpo_pkg::win_ctrl_t            ctrl
);
  import wpo_pkg::*;

  localparam int unsigned S      = WINDOW_SIDE;
  localparam int unsigned H      = S / 2;
  localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
  localparam int unsigned WID_W  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CMP_W  = (WID_W > WIDTH_FIELD_W) ? WID_W : WIDTH_FIELD_W;
  localparam int unsigned TAP_W  = (S - 1) * ENTRY_W;
  localparam int unsigned CC_W   = WID_W + 2;
  localparam int unsigned RC_W   = ROW_W + 3;

  localparam logic [CMP_W-1:0]        MAX_W_C  = CMP_W'(MAX_WIDTH);
  localparam logic [AW-1:0]           PTR_LAST = AW'(HIST_DEPTH - 1);
  localparam logic [AW:0]             DEPTH_C  = (AW + 1)'(HIST_DEPTH);
  localparam logic signed [CC_W-1:0]  H_COL    = CC_W'(H);
  localparam logic signed [RC_W-1:0]  H_ROW    = RC_W'(H);
  localparam logic signed [RC_W-1:0]  ONE_ROW  = RC_W'(1);

  logic [COL_W-1:0]        col_r;
  logic [COL_W-1:0]        col_nxt;
  logic [ROW_W-1:0]        row_r;
  logic [ROW_W-1:0]        row_nxt;
  logic [AW-1:0]           wr_ptr_r;
  logic [AW-1:0]           wr_ptr_nxt;
  logic [TAP_W-1:0]        tap_r;
  logic [WORD_W-1:0]       row_new_r;
  win_ctrl_t               ctrl_r;
  win_ctrl_t               ctrl_nxt;
  logic [WID_W-1:0]        eff_w;
  logic [COL_W-1:0]        col_cur;
  logic [ROW_W-1:0]        row_cur;
  logic [WORD_W-1:0]       word;

  // Width register clamped to 1..MAX_WIDTH.
  always_comb begin
    if (cfg.width == '0) begin
      eff_w = WID_W'(1);
    end else if (CMP_W'(cfg.width) > MAX_W_C) begin
      eff_w = WID_W'(MAX_WIDTH);
    end else begin
      eff_w = WID_W'(cfg.width);
    end
  end

  // Raster position of the arriving pixel and of the one after it.
  always_comb begin
    logic [COL_W-1:0] col_fs;
    logic [ROW_W-1:0] row_fs;
    logic [WID_W-1:0] col_inc;
    col_fs  = frame_start ? '0 : col_r;
    row_fs  = frame_start ? '0 : row_r;
    col_cur = col_fs;
    row_cur = row_fs;
    // A column beyond a width that was lowered starts the next row.
    if (WID_W'(col_fs) >= eff_w) begin
      col_cur = '0;
      row_cur = (row_fs != ROW_MAX) ? row_fs + 1'b1 : row_fs;
    end
    col_inc = WID_W'(col_cur) + 1'b1;
    if (col_inc >= eff_w) begin
      col_nxt = '0;
      row_nxt = (row_cur != ROW_MAX) ? row_cur + 1'b1 : row_cur;
    end else begin
      col_nxt = col_inc[COL_W-1:0];
      row_nxt = row_cur;
    end
    wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
  end

  // The centre lies H rows and H columns back. Stepping back over a row
  // boundary adds the width, at most H times for the narrowest image.
  always_comb begin
    logic signed [CC_W-1:0] cc;
    logic signed [RC_W-1:0] rc;
    logic signed [CC_W-1:0] w_s;
    logic signed [CC_W-1:0] cn;
    logic signed [RC_W-1:0] rn;
    w_s = $signed(CC_W'(eff_w));
    cc  = $signed(CC_W'(col_cur)) - H_COL;
    rc  = $signed(RC_W'(row_cur)) - H_ROW;
    for (int i = 0; i < H; i++) begin
      if (cc[CC_W-1]) begin
        cc = cc + w_s;
        rc = rc - ONE_ROW;
      end
    end
    ctrl_nxt = '0;
    ctrl_nxt.centre_ok = !rc[RC_W-1];
    for (int r = 0; r < S; r++) begin
      rn = rc + $signed(RC_W'(r)) - H_ROW;
      cn = cc + $signed(CC_W'(r)) - H_COL;
      ctrl_nxt.row_ok[r] = !rn[RC_W-1];
      ctrl_nxt.col_ok[r] = !cn[CC_W-1] && (cn < w_s);
    end
  end

  // Each history word holds the newest pixel and the S-1 before it, so one
  // read k rows back gives a whole window row.
  assign word    = {tap_r, mask, pix};
  assign wr_word = word;
  assign wr_addr = wr_ptr_r;

  always_comb begin
    logic [AW:0] back;
    for (int k = 1; k < S; k++) begin
      back = (AW + 1)'(k) * (AW + 1)'(eff_w);
      if ({1'b0, wr_ptr_r} >= back) begin
        rd_addr[k-1] = AW'({1'b0, wr_ptr_r} - back);
      end else begin
        rd_addr[k-1] = AW'({1'b0, wr_ptr_r} + DEPTH_C - back);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      wr_ptr_r <= '0;
      tap_r    <= '0;
    end else if (accept) begin
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      tap_r    <= word[TAP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      row_new_r <= word;
      ctrl_r    <= ctrl_nxt;
    end
  end

  assign row_new = row_new_r;
  assign ctrl    = ctrl_r;

  `WPO_ASSERT_ALWAYS(a_ptr_in_ring, wr_ptr_r <= PTR_LAST, "history write pointer left the ring")
  `WPO_ASSERT_ALWAYS(a_read_not_written, accept |-> (rd_addr[0] != wr_ptr_r), "history read hits the entry being written")
  `WPO_ASSERT_NEXT(a_col_in_row, accept, (WID_W'(col_r) < $past(eff_w)), "column index not below the image width")

endmodule

@@ rtl/core/wpo_parity_core.sv @@
`timescale 1ns / 1ps
`include "window_parity_operator_macros.svh"
module wpo_parity_core #(
  parameter  int unsigned WINDOW_SIDE = wpo_pkg::DEF_WINDOW_SIDE,
  localparam int unsigned WORD_W      = WINDOW_SIDE * wpo_pkg::ENTRY_W
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_accept,
  output logic                                  in_tready,
  input  logic [WINDOW_SIDE-1:0][WORD_W-1:0]    rows,
  input  wpo_pkg::win_ctrl_t                    ctrl,
  input  logic [wpo_pkg::SHAPE_W-1:0]           shape,
  input  logic                                  same_label,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic                                  res_valid,
  output logic                                  write_enable,
  output logic [wpo_pkg::LABEL_W-1:0]           label
);
  import wpo_pkg::*;

  localparam int unsigned S   = WINDOW_SIDE;
  localparam int unsigned H   = S / 2;
  localparam int unsigned PTS = S * S;
  localparam int unsigned CJ  = S - 1 - H;

  logic                 s1_valid_r;
  logic                 s1_valid_nxt;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  logic                 res_valid_r;
  logic                 we_r;
  logic [LABEL_W-1:0]   label_r;
  logic                 out_adv;
  logic [ENTRY_W-1:0]   centre;
  logic [PTS-1:0]       shape_ext;
  logic [PTS-1:0]       hit;
  logic                 parity;

  assign out_adv   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || out_adv;

  always_comb begin
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (out_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
    out_valid_nxt = out_adv ? s1_valid_r : out_valid_r;
  end

  // Shape bits past the window are dropped, points past the shape are off.
  assign shape_ext = PTS'(shape);
  assign centre    = rows[H][CJ*ENTRY_W +: ENTRY_W];

  always_comb begin
    logic [ENTRY_W-1:0] pt;
    logic               match;
    hit = '0;
    for (int r = 0; r < S; r++) begin
      for (int c = 0; c < S; c++) begin
        pt = rows[r][(S-1-c)*ENTRY_W +: ENTRY_W];
        if (same_label) begin
          match = (centre[PIX_W-1:0] != '0) && (pt[PIX_W-1:0] == centre[PIX_W-1:0]);
        end else begin
          match = (pt[PIX_W-1:0] != '0);
        end
        hit[r*S+c] = shape_ext[r*S+c] & ctrl.row_ok[r] & ctrl.col_ok[c] & match;
      end
    end
  end

  assign parity = ^hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Before the first centre exists every field of the result is zero.
  always_ff @(posedge clk) begin
    if (out_adv && s1_valid_r) begin
      res_valid_r <= ctrl.centre_ok;
      we_r        <= ctrl.centre_ok & centre[PIX_W];
      label_r     <= (ctrl.centre_ok && parity) ? LABEL_ODD : LABEL_EVEN;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign res_valid    = res_valid_r;
  assign write_enable = we_r;
  assign label        = label_r;

  `WPO_ASSERT_ALWAYS(a_no_centre_zero, (out_valid_r && !res_valid_r) |-> (label_r == LABEL_EVEN && !we_r), "result without a centre carries nonzero fields")
  `WPO_ASSERT_NEXT(a_stall_keeps_s1, (s1_valid_r && out_valid_r && !out_tready), s1_valid_r, "item behind a stalled result was lost")
  `WPO_ASSERT_NEXT(a_out_holds, (out_valid_r && !out_tready), (out_valid_r && $stable({res_valid_r, we_r, label_r})), "stalled result changed")

endmodule

@@ rtl/core/window_parity_operator.sv @@
`timescale 1ns / 1ps
// Channel   Ports      Direction  Carries
// input     in_*       slave      one raster pixel per item with its mask and frame mark
// result    out_*      master     one parity result per input item
// config    cfg_*      slave      window shape, same-label mode, image width
//
// One item per clock while out_tready is high; rows are registered, then the result.
// The rate is set by the history memories: each item writes one word and reads one word
// per earlier window row, all in the cycle it is taken.
// Reset is synchronous and clears positions and valid flags; history needs no clearing pass.
// A stalled result holds the output register and the stage behind it; in_tready drops
// only when both are full and out_tready is low.
module window_parity_operator #(
  parameter int unsigned MAX_WIDTH   = wpo_pkg::DEF_MAX_WIDTH,
  parameter int unsigned WINDOW_SIDE = wpo_pkg::DEF_WINDOW_SIDE
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [wpo_pkg::PIX_W-1:0]        in_tdata,     // [15:0] pixel_value
  input  logic [1:0]                       in_tuser,     // [0] mask_on, [1] frame_start
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [wpo_pkg::LABEL_W-1:0]      out_tdata,    // [7:0] label
  output logic [1:0]                       out_tuser,    // [0] result_valid, [1] write_enable
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [wpo_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [wpo_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [wpo_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                             cfg_pready
);
  import wpo_pkg::*;

  localparam int unsigned S          = WINDOW_SIDE;
  localparam int unsigned NUM_MEM    = S / 2;
  localparam int unsigned HIST_DEPTH = (S - 1) * MAX_WIDTH + 1;
  localparam int unsigned AW         = $clog2(HIST_DEPTH);
  localparam int unsigned WORD_W     = S * ENTRY_W;

  cfg_t                              cfg;
  win_ctrl_t                         ctrl;
  logic                              in_accept;
  logic [AW-1:0]                     wr_addr;
  logic [WORD_W-1:0]                 wr_word;
  logic [S-2:0][AW-1:0]              rd_addr;
  logic [2*NUM_MEM-1:0][WORD_W-1:0]  rd_word;
  logic [S-1:0][WORD_W-1:0]          rows;
  logic [WORD_W-1:0]                 row_new;
  logic                              res_valid;
  logic                              write_enable;

  assign in_accept = in_tvalid & in_tready;

  wpo_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  wpo_raster_ctrl #(
    .MAX_WIDTH   (MAX_WIDTH),
    .WINDOW_SIDE (WINDOW_SIDE)
  ) u_raster (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_accept),
    .pix         (in_tdata),
    .mask        (in_tuser[0]),
    .frame_start (in_tuser[1]),
    .cfg         (cfg),
    .wr_addr     (wr_addr),
    .wr_word     (wr_word),
    .rd_addr     (rd_addr),
    .row_new     (row_new),
    .ctrl        (ctrl)
  );

  // Identical copies of the history, two row reads per copy.
  for (genvar m = 0; m < NUM_MEM; m++) begin : g_mem
    localparam int unsigned KB = (2 * m + 1 < S - 1) ? 2 * m + 1 : 2 * m;
    wpo_hist_mem #(
      .DEPTH  (HIST_DEPTH),
      .DATA_W (WORD_W)
    ) u_mem (
      .clk       (clk),
      .wr_en     (in_accept),
      .wr_addr   (wr_addr),
      .wr_data   (wr_word),
      .rd_en     (in_accept),
      .rd_addr_a (rd_addr[2*m]),
      .rd_addr_b (rd_addr[KB]),
      .rd_data_a (rd_word[2*m]),
      .rd_data_b (rd_word[2*m+1])
    );
  end

  // Read k rows back feeds window row S-1-k; the newest row comes from the tap chain.
  for (genvar k = 1; k < S; k++) begin : g_row
    assign rows[S-1-k] = rd_word[k-1];
  end
  assign rows[S-1] = row_new;

  wpo_parity_core #(
    .WINDOW_SIDE (WINDOW_SIDE)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_accept    (in_accept),
    .in_tready    (in_tready),
    .rows         (rows),
    .ctrl         (ctrl),
    .shape        (cfg.shape),
    .same_label   (cfg.same_label),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .res_valid    (res_valid),
    .write_enable (write_enable),
    .label        (out_tdata)
  );

  assign out_tuser = {write_enable, res_valid};

endmodule
